### design/lav_pkg.sv
`timescale 1ns / 1ps
// lav_pkg: shared constants, item and vector types, rounding and saturation helpers
// for the look-at view matrix pipeline; no dependencies

package lav_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    // unit vector component: |u| <= 2^FRAC_BITS
    localparam int UW        = FRAC_BITS + 2;
    // normalizer input: covers a raw cross product of up and forward
    localparam int NW        = WORD_W + UW + 1;
    // the largest normalized magnitude lies in [2^(MB-1), 2^MB)
    localparam int MB        = 30;
    localparam int SUMW      = 2 * MB + 2;
    localparam int SQ_STEPS  = SUMW / 2;
    localparam int LENW      = MB + 1;
    localparam int NUMW      = LENW + FRAC_BITS;
    localparam int QB        = FRAC_BITS + 1;
    localparam int SATW      = 2 * WORD_W + 3;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t eye_x;
        word_t eye_y;
        word_t eye_z;
        word_t target_x;
        word_t target_y;
        word_t target_z;
        word_t up_x;
        word_t up_y;
        word_t up_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0] group_index;
        word_t      word_0;
        word_t      word_1;
        word_t      word_2;
        word_t      word_3;
        logic       last_group;
    } out_item_t;

    typedef struct packed {
        logic signed [NW-1:0] x;
        logic signed [NW-1:0] y;
        logic signed [NW-1:0] z;
    } nvec_t;

    typedef struct packed {
        logic signed [UW-1:0] x;
        logic signed [UW-1:0] y;
        logic signed [UW-1:0] z;
    } uvec_t;

    // data that rides along with a vector through the normalizer
    typedef struct packed {
        word_t e_x;
        word_t e_y;
        word_t e_z;
        word_t o_x;
        word_t o_y;
        word_t o_z;
    } tag_t;

    typedef struct packed {
        word_t r_x;
        word_t r_y;
        word_t r_z;
        word_t u_x;
        word_t u_y;
        word_t u_z;
        word_t f_x;
        word_t f_y;
        word_t f_z;
        word_t t_x;
        word_t t_y;
        word_t t_z;
    } frame_t;

    // clamp to the signed word range
    function automatic word_t sat_word(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] hi;
        logic signed [SATW-1:0] lo;
        hi = {{(SATW-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[WORD_W-1:0];
        else if (v < lo)
            return lo[WORD_W-1:0];
        else
            return v[WORD_W-1:0];
    endfunction

    // drop the fraction, nearest with ties toward +infinity
    function automatic logic signed [SATW-1:0] rnd_shr(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] half;
        half = SATW'(1) << (FRAC_BITS - 1);
        return (v + half) >>> FRAC_BITS;
    endfunction

endpackage

### design/lav_norm.sv
`timescale 1ns / 1ps
// lav_norm: pipelined vector normalizer (scale, squares, bitwise square
// root, restoring divide per lane); uses lav_pkg

module lav_norm
    import lav_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  src_valid,
    input  nvec_t src_vec,
    input  tag_t  src_tag,
    output logic  dst_valid,
    output uvec_t dst_vec,
    output tag_t  dst_tag
);

    localparam int PW = $clog2(NW);

    typedef struct packed {
        logic [2:0][MB-1:0] m;
        logic [2:0]         sgn;
        logic               nz;
        tag_t               tag;
    } side_t;

    function automatic logic [NW-1:0] mag_of(input logic signed [NW-1:0] v);
        return v[NW-1] ? NW'(-v) : NW'(v);
    endfunction

    function automatic logic [PW-1:0] msb_pos(input logic [NW-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < NW; i++)
            if (v[i])
                p = PW'(i);
        return p;
    endfunction

    // stage 1: magnitudes and signs
    logic            s1_valid_reg;
    logic [NW-1:0]   s1_mag_reg [3];
    logic [2:0]      s1_sgn_reg;
    tag_t            s1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_mag_reg[0] <= mag_of(src_vec.x);
        s1_mag_reg[1] <= mag_of(src_vec.y);
        s1_mag_reg[2] <= mag_of(src_vec.z);
        s1_sgn_reg    <= {src_vec.z[NW-1], src_vec.y[NW-1], src_vec.x[NW-1]};
        s1_tag_reg    <= src_tag;
    end

    // stage 2: leading one of the largest magnitude
    logic            s2_valid_reg;
    logic [NW-1:0]   s2_mag_reg [3];
    logic [2:0]      s2_sgn_reg;
    tag_t            s2_tag_reg;
    logic [PW-1:0]   s2_pos_reg;
    logic            s2_nz_reg;
    logic [NW-1:0]   s1_or;

    assign s1_or = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_mag_reg <= s1_mag_reg;
        s2_sgn_reg <= s1_sgn_reg;
        s2_tag_reg <= s1_tag_reg;
        s2_pos_reg <= msb_pos(s1_or);
        s2_nz_reg  <= |s1_or;
    end

    // stage 3: common shift so the largest lands just under 2^MB
    logic            s3_valid_reg;
    side_t           s3_side_reg;
    logic [MB-1:0]   s2_m [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (s2_pos_reg >= PW'(MB - 1))
                s2_m[l] = MB'(s2_mag_reg[l] >> (s2_pos_reg - PW'(MB - 1)));
            else
                s2_m[l] = MB'(s2_mag_reg[l] << (PW'(MB - 1) - s2_pos_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg.m   <= {s2_m[2], s2_m[1], s2_m[0]};
        s3_side_reg.sgn <= s2_sgn_reg;
        s3_side_reg.nz  <= s2_nz_reg;
        s3_side_reg.tag <= s2_tag_reg;
    end

    // stage 4: squares
    logic              s4_valid_reg;
    side_t             s4_side_reg;
    logic [2*MB-1:0]   s4_sq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
            s4_sq_reg[l] <= s3_side_reg.m[l] * s3_side_reg.m[l];
        s4_side_reg <= s3_side_reg;
    end

    // stage 5: sum of squares, seeds the root pipeline
    logic          sq_valid_reg [SQ_STEPS+1];
    logic [SUMW-1:0] sq_x_reg   [SQ_STEPS+1];
    logic [SUMW:0]   sq_r_reg   [SQ_STEPS+1];
    side_t           sq_side_reg[SQ_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else
            sq_valid_reg[0] <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg[0]    <= SUMW'(s4_sq_reg[0]) + SUMW'(s4_sq_reg[1]) + SUMW'(s4_sq_reg[2]);
        sq_r_reg[0]    <= '0;
        sq_side_reg[0] <= s4_side_reg;
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [SUMW:0] bit_k;
        logic [SUMW:0] trial;
        logic          fits;

        assign bit_k = (SUMW+1)'(1) << (SUMW - 2 - 2 * k);
        assign trial = sq_r_reg[k] + bit_k;
        assign fits  = {1'b0, sq_x_reg[k]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k+1] <= 1'b0;
            else
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (fits)
            begin
                sq_x_reg[k+1] <= SUMW'({1'b0, sq_x_reg[k]} - trial);
                sq_r_reg[k+1] <= (sq_r_reg[k] >> 1) + bit_k;
            end
            else
            begin
                sq_x_reg[k+1] <= sq_x_reg[k];
                sq_r_reg[k+1] <= sq_r_reg[k] >> 1;
            end
            sq_side_reg[k+1] <= sq_side_reg[k];
        end
    end

    // divide setup: numerator with half the length added for rounding
    logic            dv_valid_reg [QB+1];
    logic [NUMW-1:0] dv_rem_reg   [QB+1][3];
    logic [QB-1:0]   dv_q_reg     [QB+1][3];
    logic [LENW-1:0] dv_len_reg   [QB+1];
    side_t           dv_side_reg  [QB+1];
    logic [LENW-1:0] root_len;

    assign root_len = sq_r_reg[SQ_STEPS][LENW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            dv_rem_reg[0][l] <= (NUMW'(sq_side_reg[SQ_STEPS].m[l]) << FRAC_BITS)
                                + NUMW'(root_len >> 1);
            dv_q_reg[0][l]   <= '0;
        end
        dv_len_reg[0]  <= root_len;
        dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
    end

    // restoring divide, one quotient bit per stage, three lanes
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic [NUMW-1:0] dvs;

        assign dvs = NUMW'(dv_len_reg[j]) << (QB - 1 - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (dv_rem_reg[j][l] >= dvs)
                begin
                    dv_rem_reg[j+1][l] <= dv_rem_reg[j][l] - dvs;
                    dv_q_reg[j+1][l]   <= dv_q_reg[j][l] | (QB'(1) << (QB - 1 - j));
                end
                else
                begin
                    dv_rem_reg[j+1][l] <= dv_rem_reg[j][l];
                    dv_q_reg[j+1][l]   <= dv_q_reg[j][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            dv_len_reg[j+1]  <= dv_len_reg[j];
            dv_side_reg[j+1] <= dv_side_reg[j];
        end
    end

    // sign restore; a zero vector stays zero
    logic                 out_valid_reg;
    uvec_t                out_vec_reg;
    tag_t                 out_tag_reg;
    logic signed [UW-1:0] u_c [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (!dv_side_reg[QB].nz)
                u_c[l] = '0;
            else if (dv_side_reg[QB].sgn[l])
                u_c[l] = -UW'(dv_q_reg[QB][l]);
            else
                u_c[l] = UW'(dv_q_reg[QB][l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= dv_valid_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        out_vec_reg.x <= u_c[0];
        out_vec_reg.y <= u_c[1];
        out_vec_reg.z <= u_c[2];
        out_tag_reg   <= dv_side_reg[QB].tag;
    end

    assign dst_valid = out_valid_reg;
    assign dst_vec   = out_vec_reg;
    assign dst_tag   = out_tag_reg;

endmodule

### design/lav_frame.sv
`timescale 1ns / 1ps
// lav_frame: corrected up vector and translation terms from forward, right
// and eye, four register stages; uses lav_pkg

module lav_frame
    import lav_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   src_valid,
    input  uvec_t  fwd,
    input  uvec_t  rgt,
    input  word_t  eye_x,
    input  word_t  eye_y,
    input  word_t  eye_z,
    output logic   dst_valid,
    output frame_t dst_frame
);

    localparam int PCW = 2 * UW;
    localparam int PEW = WORD_W + UW;

    // stage 1: cross products of forward and right, dots with the eye
    logic                  f1_valid_reg;
    logic signed [PCW-1:0] f1_pc_reg [6];
    logic signed [PEW-1:0] f1_pr_reg [3];
    logic signed [PEW-1:0] f1_pf_reg [3];
    uvec_t                 f1_fwd_reg;
    uvec_t                 f1_rgt_reg;
    word_t                 f1_eye_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        f1_pc_reg[0] <= fwd.y * rgt.z;
        f1_pc_reg[1] <= fwd.z * rgt.y;
        f1_pc_reg[2] <= fwd.z * rgt.x;
        f1_pc_reg[3] <= fwd.x * rgt.z;
        f1_pc_reg[4] <= fwd.x * rgt.y;
        f1_pc_reg[5] <= fwd.y * rgt.x;
        f1_pr_reg[0] <= rgt.x * eye_x;
        f1_pr_reg[1] <= rgt.y * eye_y;
        f1_pr_reg[2] <= rgt.z * eye_z;
        f1_pf_reg[0] <= fwd.x * eye_x;
        f1_pf_reg[1] <= fwd.y * eye_y;
        f1_pf_reg[2] <= fwd.z * eye_z;
        f1_fwd_reg   <= fwd;
        f1_rgt_reg   <= rgt;
        f1_eye_reg   <= '{eye_x, eye_y, eye_z};
    end

    // stage 2: rounded up vector, x and z translation
    logic  f2_valid_reg;
    word_t f2_up_reg [3];
    word_t f2_tx_reg;
    word_t f2_tz_reg;
    uvec_t f2_fwd_reg;
    uvec_t f2_rgt_reg;
    word_t f2_eye_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_valid_reg <= 1'b0;
        else
            f2_valid_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
            f2_up_reg[l] <= sat_word(rnd_shr(SATW'(f1_pc_reg[2*l]) - SATW'(f1_pc_reg[2*l+1])));
        f2_tx_reg  <= sat_word(-rnd_shr(SATW'(f1_pr_reg[0]) + SATW'(f1_pr_reg[1])
                                        + SATW'(f1_pr_reg[2])));
        f2_tz_reg  <= sat_word(-rnd_shr(SATW'(f1_pf_reg[0]) + SATW'(f1_pf_reg[1])
                                        + SATW'(f1_pf_reg[2])));
        f2_fwd_reg <= f1_fwd_reg;
        f2_rgt_reg <= f1_rgt_reg;
        f2_eye_reg <= f1_eye_reg;
    end

    // stage 3: up dot eye products
    logic                       f3_valid_reg;
    logic signed [2*WORD_W-1:0] f3_pu_reg [3];
    word_t                      f3_up_reg [3];
    word_t                      f3_tx_reg;
    word_t                      f3_tz_reg;
    uvec_t                      f3_fwd_reg;
    uvec_t                      f3_rgt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f3_valid_reg <= 1'b0;
        else
            f3_valid_reg <= f2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
            f3_pu_reg[l] <= f2_up_reg[l] * f2_eye_reg[l];
        f3_up_reg  <= f2_up_reg;
        f3_tx_reg  <= f2_tx_reg;
        f3_tz_reg  <= f2_tz_reg;
        f3_fwd_reg <= f2_fwd_reg;
        f3_rgt_reg <= f2_rgt_reg;
    end

    // stage 4: y translation, frame assembled
    logic   f4_valid_reg;
    frame_t f4_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f4_valid_reg <= 1'b0;
        else
            f4_valid_reg <= f3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        f4_frame_reg.r_x <= WORD_W'(f3_rgt_reg.x);
        f4_frame_reg.r_y <= WORD_W'(f3_rgt_reg.y);
        f4_frame_reg.r_z <= WORD_W'(f3_rgt_reg.z);
        f4_frame_reg.u_x <= f3_up_reg[0];
        f4_frame_reg.u_y <= f3_up_reg[1];
        f4_frame_reg.u_z <= f3_up_reg[2];
        f4_frame_reg.f_x <= WORD_W'(f3_fwd_reg.x);
        f4_frame_reg.f_y <= WORD_W'(f3_fwd_reg.y);
        f4_frame_reg.f_z <= WORD_W'(f3_fwd_reg.z);
        f4_frame_reg.t_x <= f3_tx_reg;
        f4_frame_reg.t_y <= sat_word(-rnd_shr(SATW'(f3_pu_reg[0]) + SATW'(f3_pu_reg[1])
                                              + SATW'(f3_pu_reg[2])));
        f4_frame_reg.t_z <= f3_tz_reg;
    end

    assign dst_valid = f4_valid_reg;
    assign dst_frame = f4_frame_reg;

endmodule

### design/look_at_view_matrix.sv
`timescale 1ns / 1ps
// look_at_view_matrix: top level; entry stage, two normalizers, frame math,
// column serializer and register port; uses lav_pkg, lav_norm, lav_frame
//
//  channel   handshake                         payload
//  item      start in, busy out                operands (in_item_t)
//  result    done out, no stall                result (out_item_t)
//  config    psel/penable/pwrite, pready = 1   paddr, pwdata, prdata
//
// busy goes high after an accepted start and holds off new items; the spacing is
// set by the four columns the result port sends per item.
// the first column follows acceptance through two normalizers, each a
// 31-stage square root and a 17-stage divide; results follow in order.
// reset clears all valid bits and the mode register; no clearing pass.
// the receiver cannot stall, so results never wait inside the block.

module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    operands,
    output logic        done,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic       REG_TARGET_MODE = 1'b0;
    localparam logic [1:0] GRP_X = 2'd0;
    localparam logic [1:0] GRP_Y = 2'd1;
    localparam logic [1:0] GRP_Z = 2'd2;
    localparam logic [1:0] GRP_T = 2'd3;

    // register port
    logic mode_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_TARGET_MODE) ? {31'b0, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_wr && paddr[2] == REG_TARGET_MODE)
            mode_reg <= pwdata[0];
    end

    // item spacing
    logic       accept;
    logic [1:0] gap_reg;

    assign accept = start & ~busy;
    assign busy   = (gap_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= 2'd0;
        else if (accept)
            gap_reg <= 2'd3;
        else if (gap_reg != 2'd0)
            gap_reg <= gap_reg - 2'd1;
    end

    // entry stage: eye-to-target vector, or the target itself when mode_reg is set
    logic  p0_valid_reg;
    nvec_t p0_vec_reg;
    tag_t  p0_tag_reg;
    nvec_t d_c;

    always_comb
    begin
        if (mode_reg)
        begin
            d_c.x = NW'(operands.target_x);
            d_c.y = NW'(operands.target_y);
            d_c.z = NW'(operands.target_z);
        end
        else
        begin
            d_c.x = NW'(operands.target_x) - NW'(operands.eye_x);
            d_c.y = NW'(operands.target_y) - NW'(operands.eye_y);
            d_c.z = NW'(operands.target_z) - NW'(operands.eye_z);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_valid_reg <= 1'b0;
        else
            p0_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        p0_vec_reg <= d_c;
        p0_tag_reg <= '{operands.eye_x, operands.eye_y, operands.eye_z,
                        operands.up_x, operands.up_y, operands.up_z};
    end

    // forward direction before negation
    logic  n1_valid;
    uvec_t n1_vec;
    tag_t  n1_tag;

    lav_norm u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (p0_valid_reg),
        .src_vec   (p0_vec_reg),
        .src_tag   (p0_tag_reg),
        .dst_valid (n1_valid),
        .dst_vec   (n1_vec),
        .dst_tag   (n1_tag)
    );

    // negate into forward
    logic  c0_valid_reg;
    uvec_t c0_fwd_reg;
    tag_t  c0_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c0_valid_reg <= 1'b0;
        else
            c0_valid_reg <= n1_valid;
    end

    always_ff @(posedge clk)
    begin
        c0_fwd_reg.x <= -n1_vec.x;
        c0_fwd_reg.y <= -n1_vec.y;
        c0_fwd_reg.z <= -n1_vec.z;
        c0_tag_reg   <= n1_tag;
    end

    // up cross forward: products
    localparam int PRW = WORD_W + UW;

    logic                  c1_valid_reg;
    logic signed [PRW-1:0] c1_p_reg [6];
    tag_t                  c1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_valid_reg <= 1'b0;
        else
            c1_valid_reg <= c0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c1_p_reg[0] <= c0_tag_reg.o_y * c0_fwd_reg.z;
        c1_p_reg[1] <= c0_tag_reg.o_z * c0_fwd_reg.y;
        c1_p_reg[2] <= c0_tag_reg.o_z * c0_fwd_reg.x;
        c1_p_reg[3] <= c0_tag_reg.o_x * c0_fwd_reg.z;
        c1_p_reg[4] <= c0_tag_reg.o_x * c0_fwd_reg.y;
        c1_p_reg[5] <= c0_tag_reg.o_y * c0_fwd_reg.x;
        c1_tag_reg  <= '{c0_tag_reg.e_x, c0_tag_reg.e_y, c0_tag_reg.e_z,
                         WORD_W'(c0_fwd_reg.x), WORD_W'(c0_fwd_reg.y),
                         WORD_W'(c0_fwd_reg.z)};
    end

    // up cross forward: differences
    logic  c2_valid_reg;
    nvec_t c2_vec_reg;
    tag_t  c2_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_valid_reg <= 1'b0;
        else
            c2_valid_reg <= c1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c2_vec_reg.x <= NW'(c1_p_reg[0]) - NW'(c1_p_reg[1]);
        c2_vec_reg.y <= NW'(c1_p_reg[2]) - NW'(c1_p_reg[3]);
        c2_vec_reg.z <= NW'(c1_p_reg[4]) - NW'(c1_p_reg[5]);
        c2_tag_reg   <= c1_tag_reg;
    end

    // right direction
    logic  n2_valid;
    uvec_t n2_vec;
    tag_t  n2_tag;
    uvec_t n2_fwd;

    lav_norm u_norm_rgt (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (c2_valid_reg),
        .src_vec   (c2_vec_reg),
        .src_tag   (c2_tag_reg),
        .dst_valid (n2_valid),
        .dst_vec   (n2_vec),
        .dst_tag   (n2_tag)
    );

    assign n2_fwd.x = n2_tag.o_x[UW-1:0];
    assign n2_fwd.y = n2_tag.o_y[UW-1:0];
    assign n2_fwd.z = n2_tag.o_z[UW-1:0];

    // corrected up and translation
    logic   fr_valid;
    frame_t fr_frame;

    lav_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (n2_valid),
        .fwd       (n2_fwd),
        .rgt       (n2_vec),
        .eye_x     (n2_tag.e_x),
        .eye_y     (n2_tag.e_y),
        .eye_z     (n2_tag.e_z),
        .dst_valid (fr_valid),
        .dst_frame (fr_frame)
    );

    // column serializer
    frame_t    hold_reg;
    logic [1:0] grp_reg;
    logic       active_reg;
    logic       done_reg;
    out_item_t  result_reg;
    out_item_t  result_next;

    always_comb
    begin
        result_next.group_index = grp_reg;
        result_next.last_group  = (grp_reg == GRP_T);
        unique case (grp_reg)
            GRP_X:
            begin
                result_next.word_0 = hold_reg.r_x;
                result_next.word_1 = hold_reg.u_x;
                result_next.word_2 = hold_reg.f_x;
                result_next.word_3 = '0;
            end
            GRP_Y:
            begin
                result_next.word_0 = hold_reg.r_y;
                result_next.word_1 = hold_reg.u_y;
                result_next.word_2 = hold_reg.f_y;
                result_next.word_3 = '0;
            end
            GRP_Z:
            begin
                result_next.word_0 = hold_reg.r_z;
                result_next.word_1 = hold_reg.u_z;
                result_next.word_2 = hold_reg.f_z;
                result_next.word_3 = '0;
            end
            GRP_T:
            begin
                result_next.word_0 = hold_reg.t_x;
                result_next.word_1 = hold_reg.t_y;
                result_next.word_2 = hold_reg.t_z;
                result_next.word_3 = WORD_W'(1) << FRAC_BITS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            grp_reg    <= GRP_X;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= active_reg;
            if (fr_valid)
            begin
                active_reg <= 1'b1;
                grp_reg    <= GRP_X;
            end
            else if (active_reg)
            begin
                grp_reg <= grp_reg + 2'd1;
                if (grp_reg == GRP_T)
                    active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fr_valid)
            hold_reg <= fr_frame;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_group_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last_group) |=>
            (done && result.group_index == $past(result.group_index) + 2'd1))
        else $error("result columns out of order");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.last_group == (result.group_index == GRP_T)))
        else $error("last_group does not match group_index");

endmodule
